@@ design/ncs_pkg.sv @@
// Shared types, constants and handshake structs of the nearest-centroid search block.
`default_nettype none

package ncs_pkg;

    // Store geometry and sample format
    localparam int MAX_CENTROIDS = 256;
    localparam int MAX_DIMS      = 64;
    localparam int SAMPLE_BITS   = 16;
    localparam int DIST_BITS     = 38;

    localparam int CENT_IDX_W  = $clog2(MAX_CENTROIDS);
    localparam int CENT_CNT_W  = $clog2(MAX_CENTROIDS + 1);
    localparam int DIM_IDX_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int DIM_CNT_W   = $clog2(MAX_DIMS + 1);
    localparam int STORE_DEPTH = MAX_CENTROIDS << DIM_IDX_W;
    localparam int STORE_AW    = CENT_IDX_W + DIM_IDX_W;
    localparam int PROD_W      = 2 * SAMPLE_BITS;

    // Fixed field widths of the stream words
    localparam int CIDX_W       = 8;
    localparam int EIDX_W       = 6;
    localparam int CENT_CFG_W   = 9;
    localparam int DIMS_CFG_W   = 7;
    localparam int CFG_DATA_W   = 9;
    localparam int CFG_IDX_W    = 1;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 48;
    localparam int OUT_FIELDS_W = 8 + DIST_BITS;

    localparam logic [CENT_CFG_W-1:0] CENT_CFG_RESET = CENT_CFG_W'(256);
    localparam logic [DIMS_CFG_W-1:0] DIMS_CFG_RESET = DIMS_CFG_W'(64);

    typedef enum logic [0:0] {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } ncs_op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTROIDS = 1'b0,
        REG_DIMS      = 1'b1
    } ncs_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_REPORT
    } ncs_state_t;

    typedef struct packed {
        logic load_we;   // write the offered element into the centroid store
        logic start;     // latch a query element and rewind the centroid counter
        logic clear;     // restart all running sums
        logic step;      // issue the current centroid into the pipeline
        logic out_load;  // copy the best match into the output register
    } ncs_cmd_t;

    typedef struct packed {
        logic last_k;      // the current centroid is the last active one
        logic pipe_empty;  // no centroid left in flight
        logic report;      // the latched element was marked last
    } ncs_status_t;

endpackage

`default_nettype wire

@@ design/ncs_ctrl.sv @@
// Sequencer of the nearest-centroid search: input handshake, pass control, output word.
`default_nettype none

module ncs_ctrl
    import ncs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic        is_query,
    input  wire logic        elem_zero,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire ncs_status_t status,
    output ncs_cmd_t         cmd
);

    ncs_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.load_we  = accept && !is_query;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_query)
                begin
                    cmd.start  = 1'b1;
                    cmd.clear  = elem_zero;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                if (status.last_k)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.pipe_empty)
                begin
                    state_next = status.report ? ST_REPORT : ST_IDLE;
                end
            end
            ST_REPORT:
            begin
                // hold until the output register is free or being taken
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule

`default_nettype wire

@@ design/ncs_datapath.sv @@
// Datapath: config registers, centroid store, running-sum memory, MAC pipeline, min tracker.
`default_nettype none

module ncs_datapath
    import ncs_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         cfg_data,
    input  wire logic [CIDX_W-1:0]             centroid_index,
    input  wire logic [EIDX_W-1:0]             element_index,
    input  wire logic signed [SAMPLE_BITS-1:0] value,
    input  wire logic                          last_element,
    input  wire ncs_cmd_t                      cmd,
    output ncs_status_t                        status,
    output logic [CIDX_W-1:0]                  best_centroid,
    output logic [DIST_BITS-1:0]               best_distance
);

    logic [CENT_CFG_W-1:0] cent_cfg_reg;
    logic [DIMS_CFG_W-1:0] dims_cfg_reg;
    logic [CENT_CNT_W-1:0] ncent;
    logic [DIM_CNT_W-1:0]  ndims;

    logic [SAMPLE_BITS-1:0] centroid_mem [STORE_DEPTH];
    logic [DIST_BITS-1:0]   sum_mem      [MAX_CENTROIDS];
    logic [MAX_CENTROIDS-1:0] sum_valid_reg;

    logic [DIM_IDX_W-1:0]          eidx_reg;
    logic signed [SAMPLE_BITS-1:0] value_reg;
    logic                          last_reg;
    logic                          in_range_reg;
    logic [CENT_IDX_W-1:0]         k_reg;

    logic                          v1_reg, v2_reg, v3_reg;
    logic [CENT_IDX_W-1:0]         k1_reg, k2_reg, k3_reg;
    logic signed [SAMPLE_BITS-1:0] cent_rd_reg;
    logic [DIST_BITS-1:0]          sum_rd_reg;
    logic                          sum_vld_rd_reg;
    logic [SAMPLE_BITS-1:0]        mag2_reg;
    logic [DIST_BITS-1:0]          sum2_reg, sum3_reg;
    logic [PROD_W-1:0]             prod3_reg;

    logic [DIST_BITS-1:0]  best_dist_reg;
    logic [CENT_IDX_W-1:0] best_idx_reg;
    logic [CIDX_W-1:0]     out_cent_reg;
    logic [DIST_BITS-1:0]  out_dist_reg;

    logic                          store_ok;
    logic [STORE_AW-1:0]           wr_addr, rd_addr;
    logic signed [SAMPLE_BITS:0]   diff;
    logic [SAMPLE_BITS:0]          diff_abs;
    logic [SAMPLE_BITS-1:0]        mag;
    logic [DIST_BITS:0]            sum_wide;
    logic [DIST_BITS-1:0]          sum_sat;

    // Register counts: zero acts as one, too large saturates
    always_comb
    begin
        if (cent_cfg_reg == '0)
        begin
            ncent = CENT_CNT_W'(1);
        end
        else if (32'(cent_cfg_reg) > MAX_CENTROIDS)
        begin
            ncent = CENT_CNT_W'(MAX_CENTROIDS);
        end
        else
        begin
            ncent = CENT_CNT_W'(cent_cfg_reg);
        end

        if (dims_cfg_reg == '0)
        begin
            ndims = DIM_CNT_W'(1);
        end
        else if (32'(dims_cfg_reg) > MAX_DIMS)
        begin
            ndims = DIM_CNT_W'(MAX_DIMS);
        end
        else
        begin
            ndims = DIM_CNT_W'(dims_cfg_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cent_cfg_reg <= CENT_CFG_RESET;
            dims_cfg_reg <= DIMS_CFG_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CENTROIDS: cent_cfg_reg <= cfg_data[CENT_CFG_W-1:0];
                REG_DIMS:      dims_cfg_reg <= cfg_data[DIMS_CFG_W-1:0];
                default:       ;
            endcase
        end
    end

    // Centroid store: one write port for loads, one registered read port for passes
    assign store_ok = (32'(centroid_index) < MAX_CENTROIDS) && (32'(element_index) < MAX_DIMS);
    assign wr_addr  = {CENT_IDX_W'(centroid_index), DIM_IDX_W'(element_index)};
    assign rd_addr  = {k_reg, eidx_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load_we && store_ok)
        begin
            centroid_mem[wr_addr] <= value;
        end
        if (cmd.step)
        begin
            cent_rd_reg <= centroid_mem[rd_addr];
        end
    end

    // Latched query element
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            eidx_reg     <= DIM_IDX_W'(element_index);
            value_reg    <= value;
            last_reg     <= last_element;
            in_range_reg <= (DIM_CNT_W'(element_index) < ndims) && (32'(element_index) < MAX_DIMS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg  <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                k_reg <= '0;
            end
            else if (cmd.step)
            begin
                k_reg <= k_reg + CENT_IDX_W'(1);
            end
            v1_reg <= cmd.step;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Running sums: entries not written since the last restart read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= '0;
        end
        else if (cmd.clear)
        begin
            sum_valid_reg <= '0;
        end
        else if (v3_reg)
        begin
            sum_valid_reg[k3_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v3_reg)
        begin
            sum_mem[k3_reg] <= sum_sat;
        end
        if (cmd.step)
        begin
            sum_rd_reg     <= sum_mem[k_reg];
            sum_vld_rd_reg <= sum_valid_reg[k_reg];
            k1_reg         <= k_reg;
        end
    end

    // Stage 2: absolute difference
    assign diff     = {value_reg[SAMPLE_BITS-1], value_reg}
                    - {cent_rd_reg[SAMPLE_BITS-1], cent_rd_reg};
    assign diff_abs = diff[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-diff) : diff;
    assign mag      = in_range_reg ? diff_abs[SAMPLE_BITS-1:0] : '0;

    // Stage 3: square; stage 4: accumulate with saturation
    always_ff @(posedge clk)
    begin
        mag2_reg  <= mag;
        sum2_reg  <= sum_vld_rd_reg ? sum_rd_reg : '0;
        k2_reg    <= k1_reg;
        prod3_reg <= mag2_reg * mag2_reg;
        sum3_reg  <= sum2_reg;
        k3_reg    <= k2_reg;
    end

    assign sum_wide = {1'b0, sum3_reg} + (DIST_BITS+1)'(prod3_reg);
    assign sum_sat  = sum_wide[DIST_BITS] ? '1 : sum_wide[DIST_BITS-1:0];

    // Track the smallest sum; strict compare keeps the lowest index on ties
    always_ff @(posedge clk)
    begin
        if (v3_reg && ((k3_reg == '0) || (sum_sat < best_dist_reg)))
        begin
            best_dist_reg <= sum_sat;
            best_idx_reg  <= k3_reg;
        end
        if (cmd.out_load)
        begin
            out_cent_reg <= CIDX_W'(best_idx_reg);
            out_dist_reg <= best_dist_reg;
        end
    end

    assign status.last_k     = ((CENT_CNT_W'(k_reg) + CENT_CNT_W'(1)) == ncent);
    assign status.pipe_empty = !(v1_reg || v2_reg || v3_reg);
    assign status.report     = last_reg;

    assign best_centroid = out_cent_reg;
    assign best_distance = out_dist_reg;

endmodule

`default_nettype wire

@@ design/nearest_centroid_search.sv @@
// Top level of the nearest-centroid search: stream ports, config port, sequencer and datapath.
// Load word: written to the centroid store on acceptance; the input stays ready.
// Query word: one pass over the active centroids, one multiply-accumulate per cycle through a
//   four-stage pipeline; the input is not ready again until the pass has drained, and a
//   reporting word also waits until its result is loaded into the output register.
// Reset (rst_n low, asynchronous) clears control, all running sums and restores the registers
//   to 256 centroids and 64 elements; the centroid store holds no value until written.
`default_nettype none

module nearest_centroid_search
    import ncs_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // Config write channel
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,
    // Input stream
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // s_tdata: centroid_index[7:0], element_index[13:8], value[29:14], zero[31:30]
    input  wire logic [IN_TDATA_W-1:0]   s_tdata,
    // s_tuser: op (0 = load centroid element, 1 = query element)
    input  wire logic                    s_tuser,
    // s_tlast: last_element
    input  wire logic                    s_tlast,
    // Result stream
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // m_tdata: best_centroid[7:0], best_distance[45:8], zero[47:46]
    output logic [OUT_TDATA_W-1:0]       m_tdata
);

    ncs_cmd_t                      cmd;
    ncs_status_t                   status;
    logic [CIDX_W-1:0]             centroid_index;
    logic [EIDX_W-1:0]             element_index;
    logic signed [SAMPLE_BITS-1:0] value;
    logic [CIDX_W-1:0]             best_centroid;
    logic [DIST_BITS-1:0]          best_distance;

    // Unpack the input word
    assign centroid_index = s_tdata[CIDX_W-1:0];
    assign element_index  = s_tdata[CIDX_W+EIDX_W-1:CIDX_W];
    assign value          = s_tdata[CIDX_W+EIDX_W+SAMPLE_BITS-1:CIDX_W+EIDX_W];

    // Writing registers only while idle is up to the user; the block does not enforce it, so the port never stalls
    assign cfg_ready = 1'b1;

    ncs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .is_query  (s_tuser == OP_QUERY),
        .elem_zero (element_index == '0),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    ncs_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .centroid_index (centroid_index),
        .element_index  (element_index),
        .value          (value),
        .last_element   (s_tlast),
        .cmd            (cmd),
        .status         (status),
        .best_centroid  (best_centroid),
        .best_distance  (best_distance)
    );

    // Pack the result word, zero-padded to whole bytes
    assign m_tdata = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), best_distance, best_centroid};

endmodule

`default_nettype wire

@@ sim/nearest_centroid_search_tb.sv @@
// Self-checking testbench for the nearest-centroid search block.
`timescale 1ns / 100ps

module nearest_centroid_search_tb
    import ncs_pkg::*;
();

    localparam int     RESET_CYCLES  = 11;
    localparam int     MAX_GAP       = 14;
    // One query pass plus pipeline and output register, with margin
    localparam int     SETTLE_CYCLES = MAX_CENTROIDS + 16;
    localparam int     HOLD_CYCLES   = 3000;
    localparam longint CYCLE_LIMIT   = 3_000_000;
    localparam logic [DIST_BITS-1:0] DIST_CEIL = '1;

    // One expected result word
    typedef struct packed {
        logic [CIDX_W-1:0]    centroid;
        logic [DIST_BITS-1:0] distance;
    } match_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    // s_tdata: centroid_index[7:0], element_index[13:8], value[29:14], zero[31:30]
    logic [IN_TDATA_W-1:0] s_tdata;
    // s_tuser: op
    logic                  s_tuser;
    // s_tlast: last_element
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    // m_tdata: best_centroid[7:0], best_distance[45:8], zero[47:46]
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Sink handshake: per-word random gap, plus a long hold-off from its own process
    logic sink_rdy;
    logic sink_hold;
    int   hold_len;
    bit   no_idle;

    assign m_tready = sink_rdy && !sink_hold;

    // Predictor state: shadow copy of the centroid store, running sums and registers
    logic signed [SAMPLE_BITS-1:0] cent_mem [MAX_CENTROIDS][MAX_DIMS];
    logic [DIST_BITS-1:0]          run_sum  [MAX_CENTROIDS];
    logic [CENT_CFG_W-1:0]         cent_reg;
    logic [DIMS_CFG_W-1:0]         dims_reg;
    match_t                        pending_matches [$];

    int     error_count;
    int     words_sent;
    int     matches_checked;
    int     reg_writes;
    longint cycle_count;

    nearest_centroid_search u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Count cycles; give up if the run never drains
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // A count of zero acts as one, anything above the maximum saturates
    function automatic int clamp_count(input int raw, input int maxv);
        if (raw == 0)
            return 1;
        return (raw > maxv) ? maxv : raw;
    endfunction

    function automatic int active_centroids();
        return clamp_count(int'(cent_reg), MAX_CENTROIDS);
    endfunction

    function automatic int active_dims();
        return clamp_count(int'(dims_reg), MAX_DIMS);
    endfunction

    // Random element, with the two extremes drawn more often than chance
    function automatic int pick_value();
        case ($urandom_range(0, 9))
            0:       return -32768;
            1:       return 32767;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    function automatic int clamp_sample(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Update the shadow state for one accepted word; queue a match on a last query element
    task automatic score_word(input ncs_op_t op, input int cidx, input int eidx,
                              input int value, input bit last);
        int                   nc;
        int                   nd;
        longint               diff;
        logic [63:0]          acc;
        logic [DIST_BITS-1:0] best_d;
        int                   best_k;
        match_t               m;
        nc = active_centroids();
        nd = active_dims();
        if (op == OP_LOAD)
        begin
            cent_mem[cidx][eidx] = 16'(value);
        end
        else
        begin
            if (eidx == 0)
                for (int k = 0; k < MAX_CENTROIDS; k++)
                    run_sum[k] = '0;
            // Elements beyond the vector length add nothing
            if (eidx < nd)
                for (int k = 0; k < nc; k++)
                begin
                    diff = longint'(value) - longint'(cent_mem[k][eidx]);
                    if (diff < 0)
                        diff = -diff;
                    acc = 64'(run_sum[k]) + 64'(diff * diff);
                    run_sum[k] = (acc > 64'(DIST_CEIL)) ? DIST_CEIL : acc[DIST_BITS-1:0];
                end
            if (last)
            begin
                best_k = 0;
                best_d = run_sum[0];
                // Strict compare keeps the lowest index on ties
                for (int k = 1; k < nc; k++)
                    if (run_sum[k] < best_d)
                    begin
                        best_d = run_sum[k];
                        best_k = k;
                    end
                m.centroid = 8'(best_k);
                m.distance = best_d;
                pending_matches = {pending_matches, m};
            end
        end
    endtask

    // Offer one word after a random gap and hold it until accepted
    task automatic send_word(input ncs_op_t op, input int cidx, input int eidx,
                             input int value, input bit last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= last;
        s_tdata  <= {2'b00, 16'(value), 6'(eidx), 8'(cidx)};
        do
            @(posedge clk);
        while (!s_tready);
        words_sent++;
        score_word(op, cidx, eidx, value, last);
    endtask

    // Drop the input, wait for every queued match, then let any pass in flight finish
    task automatic settle_block();
        @(negedge clk);
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input ncs_reg_t idx, input int data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(data);
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_CENTROIDS)
            cent_reg = CENT_CFG_W'(data);
        else
            dims_reg = DIMS_CFG_W'(data);
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Fill every element a query can read under the current settings
    task automatic load_region();
        for (int k = 0; k < active_centroids(); k++)
            for (int e = 0; e < active_dims(); e++)
                send_word(OP_LOAD, k, e, pick_value(), ($urandom_range(0, 7) == 0));
    endtask

    // Full vector in order; mode 0 copies a centroid, 1 adds small noise, 2 is random
    task automatic send_vector(input int mode);
        int target;
        int v;
        int nd;
        nd     = active_dims();
        target = $urandom_range(0, active_centroids() - 1);
        for (int e = 0; e < nd; e++)
        begin
            case (mode)
                0:       v = int'(cent_mem[target][e]);
                1:       v = clamp_sample(int'(cent_mem[target][e]) + $urandom_range(0, 128) - 64);
                default: v = pick_value();
            endcase
            send_word(OP_QUERY, $urandom_range(0, 255), e, v, (e == nd - 1));
        end
    endtask

    // Mostly well-formed vectors; the rest reloads, stray elements and abandoned vectors
    task automatic run_mix(input int budget);
        int start;
        int pick;
        int nd;
        int e;
        int cut;
        start = words_sent;
        while (words_sent - start < budget)
        begin
            nd   = active_dims();
            pick = $urandom_range(0, 99);
            if (pick < 65)
                send_vector($urandom_range(0, 2));
            else if (pick < 77)
                send_word(OP_LOAD, $urandom_range(0, 255), $urandom_range(0, MAX_DIMS - 1),
                          pick_value(), 1'($urandom_range(0, 1)));
            else if (pick < 92)
            begin
                e = ($urandom_range(0, 1) == 0) ? $urandom_range(0, nd - 1)
                                                : $urandom_range(0, MAX_DIMS - 1);
                send_word(OP_QUERY, $urandom_range(0, 255), e, pick_value(),
                          ($urandom_range(0, 2) == 0));
            end
            else
            begin
                cut = $urandom_range(1, nd);
                for (int i = 0; i < cut; i++)
                    send_word(OP_QUERY, $urandom_range(0, 255), i, pick_value(), 1'b0);
            end
        end
    endtask

    // Registers at reset: 256 centroids and 64 elements, so column 63 spans the whole store
    task automatic test_reset_registers();
        for (int k = 0; k < MAX_CENTROIDS; k++)
            send_word(OP_LOAD, k, MAX_DIMS - 1, pick_value(), (k % 5 == 0));
        send_word(OP_QUERY, 0, MAX_DIMS - 1, 0, 1'b1);
        send_word(OP_QUERY, 255, MAX_DIMS - 1, -32768, 1'b1);
        send_word(OP_QUERY, 170, MAX_DIMS - 1, 32767, 1'b1);
        settle_block();
    endtask

    // Repeat a worst-case element without restarting until both sums pin at the ceiling
    task automatic test_sum_saturation();
        write_register(REG_CENTROIDS, 2);
        write_register(REG_DIMS, 2);
        send_word(OP_LOAD, 0, 0, 0, 1'b0);
        send_word(OP_LOAD, 0, 1, -32768, 1'b1);
        send_word(OP_LOAD, 1, 0, 0, 1'b0);
        send_word(OP_LOAD, 1, 1, -32767, 1'b0);
        send_word(OP_QUERY, 0, 0, 0, 1'b0);
        // Centroid 1 leads while the sums are below the ceiling
        for (int i = 0; i < 40; i++)
            send_word(OP_QUERY, 0, 1, 32767, (i == 39));
        // Both saturate; the tie resolves to centroid 0
        for (int i = 0; i < 30; i++)
            send_word(OP_QUERY, 0, 1, 32767, (i == 29));
        // Past the vector length: no contribution, still reports
        send_word(OP_QUERY, 0, 5, -1234, 1'b1);
        // Element 0 restarts the sums even when it is also the last one
        send_word(OP_QUERY, 0, 0, 0, 1'b1);
        settle_block();
    endtask

    // Zero and oversized counts
    task automatic test_register_limits();
        write_register(REG_CENTROIDS, 0);
        write_register(REG_DIMS, 0);
        send_word(OP_QUERY, 0, 0, 123, 1'b1);
        send_word(OP_QUERY, 0, 1, -5, 1'b1);
        settle_block();
        write_register(REG_CENTROIDS, 511);
        write_register(REG_DIMS, 127);
        send_word(OP_QUERY, 0, MAX_DIMS - 1, pick_value(), 1'b1);
        settle_block();
        write_register(REG_CENTROIDS, 257);
        write_register(REG_DIMS, 65);
        send_word(OP_QUERY, 0, MAX_DIMS - 1, pick_value(), 1'b1);
        settle_block();
    endtask

    // Three identical centroids at zero distance: the lowest index wins
    task automatic test_ties();
        int vec [3];
        vec = '{-300, 77, 32767};
        write_register(REG_CENTROIDS, 4);
        write_register(REG_DIMS, 3);
        for (int e = 0; e < 3; e++)
        begin
            send_word(OP_LOAD, 0, e, -vec[e] - 1, 1'b0);
            for (int k = 1; k < 4; k++)
                send_word(OP_LOAD, k, e, vec[e], 1'b0);
        end
        for (int e = 0; e < 3; e++)
            send_word(OP_QUERY, 0, e, vec[e], (e == 2));
        send_word(OP_QUERY, 0, 0, -vec[0] - 1, 1'b0);
        send_word(OP_QUERY, 0, 1, -vec[1] - 1, 1'b1);
        settle_block();
    endtask

    // Hold the result side for a long stretch while words keep coming back to back
    task automatic test_output_backpressure();
        no_idle  = 1'b1;
        hold_len = HOLD_CYCLES;
        for (int i = 0; i < 10; i++)
            send_vector($urandom_range(0, 2));
        no_idle = 1'b0;
        settle_block();
    endtask

    // Several settings, extremes included; each starts with a full region load
    task automatic test_random_traffic();
        int cent_list [6];
        int dims_list [6];
        int budget    [6];
        cent_list = '{4, 1, 400, 17, 3, 64};
        dims_list = '{8, 64, 1, 5, 100, 2};
        budget    = '{120, 100, 100, 130, 100, 120};
        for (int p = 0; p < 6; p++)
        begin
            settle_block();
            write_register(REG_CENTROIDS, cent_list[p]);
            write_register(REG_DIMS, dims_list[p]);
            load_region();
            // One phase runs with no idling on either side
            no_idle = (p == 3);
            run_mix(budget[p]);
            no_idle = 1'b0;
        end
    endtask

    // Long hold-off, counted here in cycles
    initial
    begin
        sink_hold = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                sink_hold <= 1'b1;
                repeat (hold_len) @(negedge clk);
                sink_hold <= 1'b0;
                hold_len = 0;
            end
        end
    end

    // Result side: random gap before each word, then wait for the handshake
    initial
    begin
        int gap;
        sink_rdy = 1'b0;
        forever
        begin
            @(negedge clk);
            gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                sink_rdy <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            sink_rdy <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
        end
    end

    // Compare each accepted result word with the oldest queued match
    initial
    begin
        match_t want;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (pending_matches.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result word: expected none, actual centroid %0d distance %0d",
                             $time, m_tdata[7:0], m_tdata[45:8]);
                end
                else
                begin
                    want = pending_matches.pop_front();
                    matches_checked++;
                    if (m_tdata[7:0] !== want.centroid)
                    begin
                        error_count++;
                        $display("%0t: best_centroid mismatch: expected %0d actual %0d",
                                 $time, want.centroid, m_tdata[7:0]);
                    end
                    if (m_tdata[45:8] !== want.distance)
                    begin
                        error_count++;
                        $display("%0t: best_distance mismatch: expected %0d actual %0d",
                                 $time, want.distance, m_tdata[45:8]);
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = REG_CENTROIDS;
        cfg_data        = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = 1'b0;
        s_tlast         = 1'b0;
        no_idle         = 1'b0;
        hold_len        = 0;
        error_count     = 0;
        words_sent      = 0;
        matches_checked = 0;
        reg_writes      = 0;
        cent_reg        = CENT_CFG_RESET;
        dims_reg        = DIMS_CFG_RESET;
        for (int k = 0; k < MAX_CENTROIDS; k++)
        begin
            run_sum[k] = '0;
            for (int e = 0; e < MAX_DIMS; e++)
                cent_mem[k][e] = '0;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_registers();
        test_sum_saturation();
        test_register_limits();
        test_ties();
        test_output_backpressure();
        test_random_traffic();
        settle_block();

        $display("Run covered %0d input words and %0d result words over %0d register writes,",
                 words_sent, matches_checked, reg_writes);
        $display("from 1 to 256 centroids and 1 to 64 elements, with a %0d-cycle output stall.",
                 HOLD_CYCLES);
        if (error_count == 0 && pending_matches.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
